### src/spe_pkg.sv
// Package for the stack pattern eraser: operation codes, register indexes,
// field widths and the command and status bundles between controller and datapath.
// No dependencies.
package spe_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned LenW      = 5;
  localparam int unsigned SymW      = 8;
  localparam int unsigned ReadIdxW  = 10;
  localparam int unsigned DepthW    = 11;
  localparam int unsigned PatW      = 128;

  localparam logic [CfgIdxW-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;      // latch the request fields
    logic push_wr;      // write the symbol on top and raise the count
    logic set_ovf;      // push dropped on a full stack
    logic clear;        // empty the stack and clear the overflow flag
    logic read_issue;   // read the entry at the requested index
    logic read_take;    // capture the read data for the result
    logic check_init;   // set up a scan of the top entries
    logic scan_issue;   // read the next entry of the scan window
    logic finish;       // pop the window if every byte matched
    logic out_load;     // present the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic full;
    logic short_stack;
    logic scan_last;
  } status_t;

endpackage

### src/spe_ctrl.sv
// Controller state machine of the stack pattern eraser.
// Sequences each request through the datapath; depends on spe_pkg.
module spe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  spe_pkg::status_t stat_i,
  output spe_pkg::cmd_t    cmd_o
);
  import spe_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_RDWAIT = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_DRAIN  = 8'b0010_0000,
    S_FINISH = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_PUSH: begin
            if (stat_i.full) begin
              cmd_o.set_ovf = 1'b1;
              state_d       = S_DONE;
            end else begin
              cmd_o.push_wr = 1'b1;
              state_d       = S_CHECK;
            end
          end
          OP_READ: begin
            cmd_o.read_issue = 1'b1;
            state_d          = S_RDWAIT;
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RDWAIT: begin
        cmd_o.read_take = 1'b1;
        state_d         = S_DONE;
      end
      S_CHECK: begin
        if (stat_i.short_stack) begin
          state_d = S_DONE;
        end else begin
          cmd_o.check_init = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // The last byte of the window is compared in this cycle.
      S_DRAIN: state_d = S_FINISH;
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted request did not enter execution");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> state_q == S_IDLE)
    else $error("controller did not return to idle after the result");

  a_drain_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN |-> $past(state_q) == S_SCAN)
    else $error("drain entered without a scan");

endmodule

### src/spe_dpath.sv
// Datapath of the stack pattern eraser: configuration registers, stack memory,
// stack count, window compare and result registers. Depends on spe_pkg.
module spe_dpath #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [1:0]                    operation_i,
  input  logic [spe_pkg::SymW-1:0]      symbol_i,
  input  logic [spe_pkg::ReadIdxW-1:0]  read_index_i,
  input  spe_pkg::cmd_t                 cmd_i,
  output spe_pkg::status_t              stat_o,
  output logic                          result_valid_o,
  output logic [spe_pkg::DepthW-1:0]    depth_o,
  output logic [spe_pkg::SymW-1:0]      read_symbol_o,
  output logic                          removed_o,
  output logic                          overflow_o
);
  import spe_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = (CW > ReadIdxW) ? CW : ReadIdxW;

  // Configuration
  logic [CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [LenW-1:0]     len_q;
  logic [PatW-1:0]     pattern;
  logic [LenW-1:0]     n_used;

  // Request
  op_e                 op_q;
  logic [SymW-1:0]     sym_q;
  logic [ReadIdxW-1:0] idx_q;

  // Stack state
  logic [SymW-1:0]     stack_mem [STACK_DEPTH];
  logic [CW-1:0]       count_q;
  logic                ovf_q;
  logic [SymW-1:0]     rdata_q;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                idx_ok;
  logic                full;

  // Scan window
  logic [AW-1:0]       base_q;
  logic [LenW-1:0]     k_q;
  logic [3:0]          cmp_k_q;
  logic                cmp_vld_q;
  logic                mismatch_q;
  logic [SymW-1:0]     pat_byte;

  // Result
  logic                removed_q;
  logic [SymW-1:0]     rsym_q;
  logic                valid_q;
  logic [DepthW-1:0]   depth_q;
  logic [SymW-1:0]     rsym_out_q;
  logic                removed_out_q;
  logic                ovf_out_q;

  assign pattern = {pat_high_q, pat_low_q};

  // A length of zero counts as one; lengths above the maximum saturate.
  always_comb begin
    if (len_q == '0) begin
      n_used = LenW'(1);
    end else if (len_q > LenW'(PATTERN_MAX)) begin
      n_used = LenW'(PATTERN_MAX);
    end else begin
      n_used = len_q;
    end
  end

  assign full   = (count_q == CW'(STACK_DEPTH));
  assign idx_ok = (IW'(idx_q) < IW'(count_q));

  assign stat_o.op          = op_q;
  assign stat_o.full        = full;
  assign stat_o.short_stack = (count_q < CW'(n_used));
  assign stat_o.scan_last   = (k_q == (n_used - LenW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      len_q      <= LenW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PATTERN_LOW:    pat_low_q  <= cfg_wdata_i;
        REG_PATTERN_HIGH:   pat_high_q <= cfg_wdata_i;
        REG_PATTERN_LENGTH: len_q      <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_e'(operation_i);
      sym_q <= symbol_i;
      idx_q <= read_index_i;
    end
  end

  // Stack memory: one write and one registered read port.
  assign rd_en   = cmd_i.read_issue || cmd_i.scan_issue;
  assign rd_addr = cmd_i.scan_issue ? (base_q + AW'(k_q)) : AW'(IW'(idx_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      stack_mem[count_q[AW-1:0]] <= sym_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.push_wr) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.finish && !mismatch_q) begin
        count_q <= count_q - CW'(n_used);
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end else if (cmd_i.clear) begin
        ovf_q <= 1'b0;
      end
    end
  end

  assign pat_byte = pattern[{cmp_k_q, 3'b000} +: SymW];

  // Reads of the window are issued one per cycle; each byte is compared
  // with its pattern byte in the cycle after its read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check_init) begin
      base_q     <= AW'(count_q - CW'(n_used));
      k_q        <= '0;
      mismatch_q <= 1'b0;
    end else begin
      if (cmd_i.scan_issue) begin
        k_q     <= k_q + LenW'(1);
        cmp_k_q <= k_q[3:0];
      end
      if (cmp_vld_q && (rdata_q != pat_byte)) begin
        mismatch_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      removed_q <= 1'b0;
      rsym_q    <= '0;
    end else begin
      if (cmd_i.finish && !mismatch_q) begin
        removed_q <= 1'b1;
      end
      if (cmd_i.read_take && idx_ok) begin
        rsym_q <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      depth_q       <= DepthW'(count_q);
      rsym_out_q    <= rsym_q;
      removed_out_q <= removed_q;
      ovf_out_q     <= ovf_q;
    end
  end

  assign result_valid_o = valid_q;
  assign depth_o        = depth_q;
  assign read_symbol_o  = rsym_out_q;
  assign removed_o      = removed_out_q;
  assign overflow_o     = ovf_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond the stack depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_wr |-> !full)
    else $error("write to a full stack");

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> (k_q < n_used) && (IW'(rd_addr) < IW'(count_q)))
    else $error("scan read outside the pattern window");

endmodule

### src/stack_pattern_eraser_core.sv
// Top level of the stack pattern eraser: joins the controller and the datapath.
// Depends on spe_pkg, spe_ctrl and spe_dpath.
//
//   channel   handshake            fields
//   request   start_i / busy_o     operation_i, symbol_i, read_index_i
//   result    result_valid_o       depth_o, read_symbol_o, removed_o, overflow_o
//   config    cfg_we_i             cfg_index_i, cfg_wdata_i
//
// A request is taken when start_i is high and busy_o is low. For a push that can
// be checked, with n the pattern length in use, the top n stack entries are read
// from the single-read-port stack memory one per cycle and compared.
// Each result is shown for one cycle with result_valid_o and cannot be held
// off. Reset is asynchronous and active low; the stack memory needs no clearing.
module stack_pattern_eraser_core #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    operation_i,
  input  logic [spe_pkg::SymW-1:0]      symbol_i,
  input  logic [spe_pkg::ReadIdxW-1:0]  read_index_i,
  output logic                          result_valid_o,
  output logic [spe_pkg::DepthW-1:0]    depth_o,
  output logic [spe_pkg::SymW-1:0]      read_symbol_o,
  output logic                          removed_o,
  output logic                          overflow_o,
  input  logic                          cfg_we_i,
  input  logic [spe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spe_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import spe_pkg::*;

  cmd_t    cmd;
  status_t stat;

  spe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  spe_dpath #(
    .STACK_DEPTH(STACK_DEPTH),
    .PATTERN_MAX(PATTERN_MAX)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .symbol_i      (symbol_i),
    .read_index_i  (read_index_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_valid_o(result_valid_o),
    .depth_o       (depth_o),
    .read_symbol_o (read_symbol_o),
    .removed_o     (removed_o),
    .overflow_o    (overflow_o)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for stack_pattern_eraser_core: a directed table, then random
// pattern sequences and a stack-fill run, each result checked against the table or a local model.
// Depends on spe_pkg and the RTL below stack_pattern_eraser_core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth = 1024;
  localparam int unsigned PatternMax = 16;
  localparam logic [spe_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [spe_pkg::DepthW-1:0] depth;
    logic [spe_pkg::SymW-1:0]   rd_sym;
    logic                       removed;
    logic                       ovf;
  } outcome_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    spe_pkg::op_e                 op;
    logic [spe_pkg::SymW-1:0]     sym;
    logic [spe_pkg::ReadIdxW-1:0] idx;
    logic [spe_pkg::CfgIdxW-1:0]  reg_idx;
    logic [spe_pkg::CfgDataW-1:0] data;
    logic                         typed;
    outcome_t                     want;
  } row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [1:0]                    operation_i;
  logic [spe_pkg::SymW-1:0]      symbol_i;
  logic [spe_pkg::ReadIdxW-1:0]  read_index_i;
  logic                          result_valid_o;
  logic [spe_pkg::DepthW-1:0]    depth_o;
  logic [spe_pkg::SymW-1:0]      read_symbol_o;
  logic                          removed_o;
  logic                          overflow_o;
  logic                          cfg_we_i;
  logic [spe_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [spe_pkg::CfgDataW-1:0]  cfg_wdata_i;

  // Local copy of the eraser state and its pattern registers.
  logic [7:0]  stk_mem [StackDepth];
  int unsigned stk_count;
  logic        stk_ovf;
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [4:0]  pat_len;

  outcome_t pending_results [$];
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned error_count;
  int unsigned erased_count;
  int unsigned dropped_count;
  int unsigned peak_depth;
  bit          gaps_on;

  row_t directed_plan [0:21] = '{
    '{ROW_REQ, spe_pkg::OP_NOP,   8'h00, 10'd0,   REG_SPARE, 64'd0, 1'b1,
      '{11'd0, 8'h00, 1'b0, 1'b0}},
    '{ROW_REQ, spe_pkg::OP_READ,  8'h00, 10'd0,   REG_SPARE, 64'd0, 1'b1,
      '{11'd0, 8'h00, 1'b0, 1'b0}},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'h00, 10'd0,   REG_SPARE, 64'd0, 1'b1,
      '{11'd0, 8'h00, 1'b1, 1'b0}},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'hFF, 10'd0,   REG_SPARE, 64'd0, 1'b1,
      '{11'd1, 8'h00, 1'b0, 1'b0}},
    '{ROW_REQ, spe_pkg::OP_READ,  8'h00, 10'd0,   REG_SPARE, 64'd0, 1'b1,
      '{11'd1, 8'hFF, 1'b0, 1'b0}},
    '{ROW_REQ, spe_pkg::OP_READ,  8'h00, 10'h3FF, REG_SPARE, 64'd0, 1'b1,
      '{11'd1, 8'h00, 1'b0, 1'b0}},
    '{ROW_REQ, spe_pkg::OP_CLEAR, 8'h00, 10'd0,   REG_SPARE, 64'd0, 1'b1,
      '{11'd0, 8'h00, 1'b0, 1'b0}},
    '{ROW_REG, spe_pkg::OP_NOP,   8'h00, 10'd0,   spe_pkg::REG_PATTERN_LOW,
      64'h5AA5_C33C_0FF0_4241, 1'b0, '0},
    '{ROW_REG, spe_pkg::OP_NOP,   8'h00, 10'd0,   spe_pkg::REG_PATTERN_LENGTH,
      64'd2, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'h41, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'h41, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'h42, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'h42, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'h42, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0},
    '{ROW_REG, spe_pkg::OP_NOP,   8'h00, 10'd0,   spe_pkg::REG_PATTERN_LENGTH,
      64'd0, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'h41, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0},
    '{ROW_REG, spe_pkg::OP_NOP,   8'h00, 10'd0,   spe_pkg::REG_PATTERN_HIGH,
      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{ROW_REG, spe_pkg::OP_NOP,   8'h00, 10'd0,   spe_pkg::REG_PATTERN_LENGTH,
      64'd31, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_PUSH,  8'hFF, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0},
    '{ROW_REG, spe_pkg::OP_NOP,   8'h00, 10'd0,   REG_SPARE,
      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_READ,  8'h00, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0},
    '{ROW_REQ, spe_pkg::OP_CLEAR, 8'h00, 10'd0,   REG_SPARE, 64'd0, 1'b0, '0}
  };

  stack_pattern_eraser_core #(
    .STACK_DEPTH(StackDepth),
    .PATTERN_MAX(PatternMax)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .symbol_i      (symbol_i),
    .read_index_i  (read_index_i),
    .result_valid_o(result_valid_o),
    .depth_o       (depth_o),
    .read_symbol_o (read_symbol_o),
    .removed_o     (removed_o),
    .overflow_o    (overflow_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned pattern_span();
    if (pat_len == 5'd0) return 1;
    if (pat_len > PatternMax) return PatternMax;
    return pat_len;
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned k);
    return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
  endfunction

  // Applies one request to the local stack and returns the result it must produce.
  function automatic outcome_t erase_step(spe_pkg::op_e op, logic [7:0] sym,
                                          logic [9:0] idx);
    outcome_t    res;
    int unsigned n;
    int unsigned k;
    bit          hit;
    res = '0;
    case (op)
      spe_pkg::OP_PUSH: begin
        if (stk_count >= StackDepth) begin
          stk_ovf = 1'b1;
          dropped_count++;
        end else begin
          n = pattern_span();
          stk_mem[stk_count] = sym;
          stk_count++;
          hit = 1'b0;
          if (stk_count >= n) begin
            hit = 1'b1;
            for (k = 0; k < n; k++) begin
              if (stk_mem[stk_count-n+k] != pattern_byte(k)) hit = 1'b0;
            end
          end
          if (hit) begin
            stk_count -= n;
            res.removed = 1'b1;
            erased_count++;
          end
        end
      end
      spe_pkg::OP_READ: begin
        if (idx < stk_count) res.rd_sym = stk_mem[idx];
      end
      spe_pkg::OP_CLEAR: begin
        stk_count = 0;
        stk_ovf = 1'b0;
      end
      default: ;
    endcase
    if (stk_count > peak_depth) peak_depth = stk_count;
    res.depth = stk_count[spe_pkg::DepthW-1:0];
    res.ovf = stk_ovf;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("result %0d: %s is %0h, expected %0h", results_checked, what, got, want);
    error_count++;
  endtask

  // Stops the sender and waits until every outstanding request has produced its result.
  task automatic settle();
    if (start_i) start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] reg_idx, logic [63:0] data, bit hold);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (reg_idx)
      spe_pkg::REG_PATTERN_LOW:    pat_lo = data;
      spe_pkg::REG_PATTERN_HIGH:   pat_hi = data;
      spe_pkg::REG_PATTERN_LENGTH: pat_len = data[4:0];
      default: ;
    endcase
    // Back-to-back writes keep the enable high rather than pulsing it.
    if (!hold) cfg_we_i <= 1'b0;
  endtask

  task automatic issue(spe_pkg::op_e op, logic [7:0] sym, logic [9:0] idx,
                       bit typed = 1'b0, outcome_t want = '0);
    outcome_t predicted;
    while (gaps_on && $urandom_range(99) < 22) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    operation_i  <= op;
    symbol_i     <= sym;
    read_index_i <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predicted = erase_step(op, sym, idx);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // Pushes the whole pattern, with up to nest further copies nested inside it and occasional
  // random bytes between, so that an inner removal can let the outer copy close up and be removed in turn.
  task automatic push_nested(int unsigned n, int unsigned nest);
    int unsigned split;
    int unsigned k;
    split = $urandom_range(n - 1);
    for (k = 0; k < n; k++) begin
      if (nest > 0 && k == split) push_nested(n, nest - 1);
      if ($urandom_range(99) < 8) issue(spe_pkg::OP_PUSH, 8'($urandom), 10'($urandom));
      issue(spe_pkg::OP_PUSH, pattern_byte(k), 10'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned phase, int unsigned items);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    int unsigned phase_end;
    int unsigned pick;
    int unsigned k;
    int unsigned n;
    logic [9:0]  idx;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    // A narrow byte alphabet makes overlapping and self-similar patterns likely.
    if ($urandom_range(1)) begin
      lo = (lo & 64'h0303_0303_0303_0303) | 64'h6060_6060_6060_6060;
      hi = (hi & 64'h0303_0303_0303_0303) | 64'h6060_6060_6060_6060;
    end
    case (phase % 5)
      0: len = 5'd1;
      1: len = 5'd16;
      2: len = 5'd0;
      3: len = 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(2, 15));
    endcase
    write_reg(spe_pkg::REG_PATTERN_LOW, lo, 1'b1);
    write_reg(spe_pkg::REG_PATTERN_HIGH, hi, 1'b1);
    write_reg(spe_pkg::REG_PATTERN_LENGTH, {59'($urandom), len}, 1'b0);
    if ($urandom_range(1)) issue(spe_pkg::OP_CLEAR, 8'($urandom), 10'($urandom));
    n = pattern_span();
    phase_end = requests_sent + items;
    while (requests_sent < phase_end) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_nested(n, $urandom_range(2));
      end else if (pick < 58) begin
        for (k = 0; k < $urandom_range(1, n); k++)
          issue(spe_pkg::OP_PUSH, pattern_byte(k), 10'($urandom));
      end else if (pick < 75) begin
        issue(spe_pkg::OP_PUSH, 8'($urandom), 10'($urandom));
      end else if (pick < 90) begin
        idx = (stk_count > 0 && $urandom_range(3) != 0) ?
              10'($urandom_range(stk_count - 1)) : 10'($urandom);
        issue(spe_pkg::OP_READ, 8'($urandom), idx);
      end else if (pick < 94) begin
        issue(spe_pkg::OP_NOP, 8'($urandom), 10'($urandom));
      end else if (pick < 97) begin
        issue(spe_pkg::OP_CLEAR, 8'($urandom), 10'($urandom));
      end else begin
        settle();
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, depth", depth_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (depth_o !== want.depth) report_mismatch("depth", depth_o, want.depth);
        if (read_symbol_o !== want.rd_sym)
          report_mismatch("read_symbol", read_symbol_o, want.rd_sym);
        if (removed_o !== want.removed) report_mismatch("removed", removed_o, want.removed);
        if (overflow_o !== want.ovf) report_mismatch("overflow", overflow_o, want.ovf);
      end
      results_checked++;
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned phase;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    operation_i  = spe_pkg::OP_NOP;
    symbol_i     = '0;
    read_index_i = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    stk_count    = 0;
    stk_ovf      = 1'b0;
    pat_lo       = '0;
    pat_hi       = '0;
    pat_len      = 5'd1;
    gaps_on      = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < $size(directed_plan); r++) begin
      if (directed_plan[r].kind == ROW_REG)
        write_reg(directed_plan[r].reg_idx, directed_plan[r].data,
                  r + 1 < $size(directed_plan) && directed_plan[r+1].kind == ROW_REG);
      else
        issue(directed_plan[r].op, directed_plan[r].sym, directed_plan[r].idx,
              directed_plan[r].typed, directed_plan[r].want);
    end

    for (phase = 0; phase < 8; phase++) begin
      gaps_on = (phase != 2);
      random_phase(phase, 20);
    end
    gaps_on = 1'b1;

    // Fill the stack with bytes that can never complete the all-zero pattern,
    // then push into the full stack and check that a clear drops the flag.
    write_reg(spe_pkg::REG_PATTERN_LOW, '0, 1'b1);
    write_reg(spe_pkg::REG_PATTERN_HIGH, '0, 1'b1);
    write_reg(spe_pkg::REG_PATTERN_LENGTH, 64'd16, 1'b0);
    issue(spe_pkg::OP_CLEAR, 8'h00, 10'd0);
    while (stk_count < StackDepth) begin
      // The first quarter of the fill runs without any idle cycles.
      gaps_on = (stk_count >= StackDepth / 4);
      issue(spe_pkg::OP_PUSH, 8'($urandom_range(1, 255)), 10'($urandom));
    end
    gaps_on = 1'b1;
    issue(spe_pkg::OP_PUSH, 8'h00, 10'd0);
    issue(spe_pkg::OP_PUSH, 8'hFF, 10'h3FF);
    issue(spe_pkg::OP_READ, 8'h00, 10'h3FF);
    issue(spe_pkg::OP_READ, 8'h00, 10'd0);
    issue(spe_pkg::OP_NOP, 8'h00, 10'd0);
    issue(spe_pkg::OP_CLEAR, 8'h00, 10'd0);
    issue(spe_pkg::OP_READ, 8'h00, 10'd0);

    settle();
    repeat (30) @(posedge clk_i);

    $display("Ran %0d requests: directed table, eight random patterns, full stack; %0d checked.",
             requests_sent, results_checked);
    $display("Pushes that erased a match: %0d, dropped on a full stack: %0d, peak depth %0d.",
             erased_count, dropped_count, peak_depth);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #6ms;
    $display("simulation failed");
    $finish;
  end

endmodule
